@@ hw/rtl/swept_box_time_of_impact_unit_defines.svh @@
// Assertion macros used by the checker file of the swept box time of impact unit
`ifndef SWEPT_BOX_TIME_OF_IMPACT_UNIT_DEFINES_SVH
`define SWEPT_BOX_TIME_OF_IMPACT_UNIT_DEFINES_SVH

// property checked only out of reset
`define SBTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked during reset as well
`define SBTI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/sbti_pkg.sv @@
// Types and constants of the swept box time of impact unit
package sbti_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned HALF_W  = 23;
  localparam int unsigned TIME_W  = 24;
  localparam int unsigned GAP_W   = 26;
  localparam int unsigned SPD_W   = 25;
  localparam int unsigned PROD_W  = 51;
  localparam int unsigned NUM_W   = 48;
  localparam int unsigned FRAC_T  = 16;
  localparam int unsigned MARG_W  = 8;

  localparam logic [TIME_W-1:0] TIME_MAX     = 24'hFFFFFF;
  localparam logic [MARG_W-1:0] MARGIN_RESET = 8'd3;

  // one request as it enters the pipeline
  typedef struct packed {
    logic signed [POS_W-1:0]  mover_x;
    logic signed [POS_W-1:0]  mover_y;
    logic        [HALF_W-1:0] mover_half_w;
    logic        [HALF_W-1:0] mover_half_h;
    logic signed [POS_W-1:0]  mover_vx;
    logic signed [POS_W-1:0]  mover_vy;
    logic signed [POS_W-1:0]  obstacle_x;
    logic signed [POS_W-1:0]  obstacle_y;
    logic        [HALF_W-1:0] obstacle_half_w;
    logic        [HALF_W-1:0] obstacle_half_h;
    logic        [TIME_W-1:0] step_time;
  } item_t;

  // classified request: side or corner test operands
  typedef struct packed {
    logic                    miss;
    logic                    overlap;
    logic                    corner;
    logic                    cross_nz;
    logic signed [GAP_W-1:0] nx;
    logic signed [GAP_W-1:0] ny;
    logic signed [GAP_W-1:0] fx;
    logic signed [GAP_W-1:0] fy;
    logic signed [SPD_W-1:0] spx;
    logic signed [SPD_W-1:0] spy;
    logic        [TIME_W-1:0] dt;
  } sel_t;

  // divider stage contents; q holds the final time when fixed is set
  typedef struct packed {
    logic              hit;
    logic              fixed;
    logic [NUM_W-1:0]  rem;
    logic [TIME_W-1:0] den;
    logic [TIME_W-1:0] q;
  } div_t;

endpackage

@@ hw/rtl/sbti_in_if.sv @@
// Request channel of the swept box time of impact unit
interface sbti_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sbti_pkg::POS_W-1:0]    mover_x;
  logic signed [sbti_pkg::POS_W-1:0]    mover_y;
  logic        [sbti_pkg::HALF_W-1:0]   mover_half_w;
  logic        [sbti_pkg::HALF_W-1:0]   mover_half_h;
  logic signed [sbti_pkg::POS_W-1:0]    mover_vx;
  logic signed [sbti_pkg::POS_W-1:0]    mover_vy;
  logic signed [sbti_pkg::POS_W-1:0]    obstacle_x;
  logic signed [sbti_pkg::POS_W-1:0]    obstacle_y;
  logic        [sbti_pkg::HALF_W-1:0]   obstacle_half_w;
  logic        [sbti_pkg::HALF_W-1:0]   obstacle_half_h;
  logic        [sbti_pkg::TIME_W-1:0]   step_time;

  modport source (output valid, mover_x, mover_y, mover_half_w, mover_half_h, mover_vx,
                  mover_vy, obstacle_x, obstacle_y, obstacle_half_w, obstacle_half_h,
                  step_time, input ready);
  modport sink (input valid, mover_x, mover_y, mover_half_w, mover_half_h, mover_vx,
                mover_vy, obstacle_x, obstacle_y, obstacle_half_w, obstacle_half_h,
                step_time, output ready);
endinterface

@@ hw/rtl/sbti_out_if.sv @@
// Result channel of the swept box time of impact unit
interface sbti_out_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic [sbti_pkg::TIME_W-1:0]        contact_time;

  modport source (output valid, hit, contact_time, input ready);
  modport sink (input valid, hit, contact_time, output ready);
endinterface

@@ hw/rtl/swept_box_time_of_impact_unit.sv @@
// Top level of the swept box time of impact unit
// Usage:
//   in_req  carries one moving box, one static box and a time step per request.
//   out_rsp returns one result per request, in order: hit and contact_time (Q8.16).
//   cfg_we / cfg_wdata write contact_margin; write only while the unit is empty.
// Pipeline: a request passes 2 classify stages, 2 test stages and 24 divider
//   stages before its result is presented on out_rsp.
// Throughput: one request per cycle while out_rsp is not held; the 24-stage quotient
//   pipeline, one bit per stage, sets the depth.
// Stall: all stages advance together; while out_rsp holds a result that is not
//   taken, in_req.ready is low and nothing moves, so no request is lost or repeated.
//   in_req.ready = !out_rsp.valid || out_rsp.ready.
// Reset: rst_n low for one edge empties the pipeline and sets contact_margin to 3.
module swept_box_time_of_impact_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  sbti_in_if.sink                       in_req,
  sbti_out_if.source                    out_rsp,
  input  logic                          cfg_we,
  input  logic [sbti_pkg::MARG_W-1:0]   cfg_wdata
);

  logic                         advance;
  logic [sbti_pkg::MARG_W-1:0]  margin_r;
  sbti_pkg::item_t              item;
  logic                         sel_valid, div_valid, res_valid;
  sbti_pkg::sel_t               sel;
  sbti_pkg::div_t               div_in, res;

  // margin register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= sbti_pkg::MARGIN_RESET;
    end else if (cfg_we) begin
      margin_r <= cfg_wdata;
    end
  end

  // whole pipeline moves unless the output is held
  assign advance      = !res_valid || out_rsp.ready;
  assign in_req.ready = advance;

  assign item.mover_x         = in_req.mover_x;
  assign item.mover_y         = in_req.mover_y;
  assign item.mover_half_w    = in_req.mover_half_w;
  assign item.mover_half_h    = in_req.mover_half_h;
  assign item.mover_vx        = in_req.mover_vx;
  assign item.mover_vy        = in_req.mover_vy;
  assign item.obstacle_x      = in_req.obstacle_x;
  assign item.obstacle_y      = in_req.obstacle_y;
  assign item.obstacle_half_w = in_req.obstacle_half_w;
  assign item.obstacle_half_h = in_req.obstacle_half_h;
  assign item.step_time       = in_req.step_time;

  sbti_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .in_valid  (in_req.valid),
    .in_item   (item),
    .sel_valid (sel_valid),
    .sel       (sel)
  );

  sbti_test u_test (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .margin    (margin_r),
    .sel_valid (sel_valid),
    .sel       (sel),
    .div_valid (div_valid),
    .div_in    (div_in)
  );

  sbti_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .div_valid (div_valid),
    .div_in    (div_in),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_rsp.valid        = res_valid;
  assign out_rsp.hit          = res.hit;
  assign out_rsp.contact_time = res.q;

endmodule

@@ hw/rtl/sbti_classify.sv @@
// Gap computation and side/corner classification (two stages)
module sbti_classify (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  sbti_pkg::item_t     in_item,
  output logic                sel_valid,
  output sbti_pkg::sel_t      sel
);

  logic signed [sbti_pkg::GAP_W-1:0] x12_r, x21_r, y12_r, y21_r;
  logic signed [sbti_pkg::GAP_W-1:0] x12_nxt, x21_nxt, y12_nxt, y21_nxt;
  logic signed [sbti_pkg::POS_W-1:0] vx_r, vy_r;
  logic        [sbti_pkg::TIME_W-1:0] dt_r;
  logic                               v1_r, v2_r;
  sbti_pkg::sel_t                     sel_r, sel_nxt;

  // stage 1: center distance and edge gaps on both axes
  always_comb begin
    logic signed [sbti_pkg::GAP_W-1:0] dx, dy, ws, hs;
    dx = $signed({{2{in_item.mover_x[23]}}, in_item.mover_x})
       - $signed({{2{in_item.obstacle_x[23]}}, in_item.obstacle_x});
    dy = $signed({{2{in_item.mover_y[23]}}, in_item.mover_y})
       - $signed({{2{in_item.obstacle_y[23]}}, in_item.obstacle_y});
    ws = $signed({3'b000, in_item.mover_half_w}) + $signed({3'b000, in_item.obstacle_half_w});
    hs = $signed({3'b000, in_item.mover_half_h}) + $signed({3'b000, in_item.obstacle_half_h});
    x12_nxt = dx - ws;
    x21_nxt = -dx - ws;
    y12_nxt = dy - hs;
    y21_nxt = -dy - hs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x12_r <= x12_nxt;
      x21_r <= x21_nxt;
      y12_r <= y12_nxt;
      y21_r <= y21_nxt;
      vx_r  <= in_item.mover_vx;
      vy_r  <= in_item.mover_vy;
      dt_r  <= in_item.step_time;
    end
  end

  // stage 2: which side the mover sits on, and test operands for that case
  always_comb begin
    logic xp, xn, yp, yn, mx, my;
    logic signed [sbti_pkg::SPD_W-1:0] vxe, vye, cr;
    logic signed [sbti_pkg::GAP_W-1:0] fu, fd;
    vxe = $signed({vx_r[23], vx_r});
    vye = $signed({vy_r[23], vy_r});
    xp = 1'b0; xn = 1'b0; yp = 1'b0; yn = 1'b0; mx = 1'b0; my = 1'b0;
    cr = '0; fu = '0; fd = '0;
    if (x12_r >= 0) begin
      xp = 1'b1;
      mx = (vxe >= 0);
    end else if (x21_r >= 0) begin
      xn = 1'b1;
      mx = (vxe <= 0);
    end
    if (y12_r >= 0) begin
      yp = 1'b1;
      my = (vye >= 0);
    end else if (y21_r >= 0) begin
      yn = 1'b1;
      my = (vye <= 0);
    end

    sel_nxt          = '0;
    sel_nxt.dt       = dt_r;
    sel_nxt.miss     = mx | my;
    sel_nxt.corner   = (xp | xn) & (yp | yn);
    sel_nxt.overlap  = !(xp | xn | yp | yn);

    if (xp && yn) begin
      sel_nxt.nx = x12_r;  sel_nxt.ny = y21_r;  sel_nxt.fx = -x21_r; sel_nxt.fy = -y12_r;
      sel_nxt.spx = -vxe;  sel_nxt.spy = vye;
    end else if (xp && yp) begin
      sel_nxt.nx = x12_r;  sel_nxt.ny = y12_r;  sel_nxt.fx = -x21_r; sel_nxt.fy = -y21_r;
      sel_nxt.spx = -vxe;  sel_nxt.spy = -vye;
    end else if (xn && yn) begin
      sel_nxt.nx = x21_r;  sel_nxt.ny = y21_r;  sel_nxt.fx = -x12_r; sel_nxt.fy = -y12_r;
      sel_nxt.spx = vxe;   sel_nxt.spy = vye;
    end else if (xn && yp) begin
      sel_nxt.nx = x21_r;  sel_nxt.ny = y12_r;  sel_nxt.fx = -x12_r; sel_nxt.fy = -y21_r;
      sel_nxt.spx = vxe;   sel_nxt.spy = -vye;
    end else begin
      // side cases: nx is the gap, spx the closing speed, spy the cross speed magnitude
      if (xp) begin
        sel_nxt.nx = x12_r; sel_nxt.spx = -vxe; cr = vye; fu = -y12_r; fd = -y21_r;
      end else if (xn) begin
        sel_nxt.nx = x21_r; sel_nxt.spx = vxe;  cr = vye; fu = -y12_r; fd = -y21_r;
      end else if (yn) begin
        sel_nxt.nx = y21_r; sel_nxt.spx = vye;  cr = vxe; fu = -x12_r; fd = -x21_r;
      end else begin
        sel_nxt.nx = y12_r; sel_nxt.spx = -vye; cr = vxe; fu = -x12_r; fd = -x21_r;
      end
      sel_nxt.cross_nz = (cr != 0);
      sel_nxt.spy      = cr[sbti_pkg::SPD_W-1] ? -cr : cr;
      sel_nxt.fy       = cr[sbti_pkg::SPD_W-1] ? fd : fu;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_r <= sel_nxt;
    end
  end

  assign sel_valid = v2_r;
  assign sel       = sel_r;

endmodule

@@ hw/rtl/sbti_test.sv @@
// Reach and angle products, then hit decision and divider setup (two stages)
module sbti_test (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic [sbti_pkg::MARG_W-1:0]       margin,
  input  logic                              sel_valid,
  input  sbti_pkg::sel_t                    sel,
  output logic                              div_valid,
  output sbti_pkg::div_t                    div_in
);

  localparam int unsigned PW = sbti_pkg::PROD_W;
  localparam int unsigned GW = sbti_pkg::GAP_W;
  localparam int unsigned SW = sbti_pkg::SPD_W;
  localparam int unsigned TW = sbti_pkg::TIME_W;

  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [GW-1:0] nx_r, ny_r;
  logic        [GW-1:0] gx_r, gy_r, gx_nxt, gy_nxt;
  logic                 satx_r, saty_r, satx_nxt, saty_nxt;
  logic        [TW-1:0] spx_r, spy_r, dt_r;
  logic                 miss_r, overlap_r, corner_r, cnz_r, v3_r, v4_r;
  sbti_pkg::div_t       div_r, div_nxt;

  function automatic logic signed [PW-1:0] sx_g(input logic signed [GW-1:0] a);
    sx_g = $signed({{(PW-GW){a[GW-1]}}, a});
  endfunction

  function automatic logic signed [PW-1:0] sx_s(input logic signed [SW-1:0] a);
    sx_s = $signed({{(PW-SW){a[SW-1]}}, a});
  endfunction

  // gap less margin, floored at zero, and the saturation check for one axis
  function automatic logic [GW:0] gap_of(input logic signed [GW-1:0] n,
                                         input logic [sbti_pkg::MARG_W-1:0] m,
                                         input logic signed [SW-1:0] sp);
    logic signed [GW-1:0] me;
    logic [GW-1:0] g;
    logic sat;
    me  = $signed({{(GW-sbti_pkg::MARG_W){1'b0}}, m});
    g   = (n > me) ? $unsigned(n - me) : '0;
    sat = ({6'b0, g} >= {sp[TW-1:0], 8'b0});
    gap_of = {sat, g};
  endfunction

  // stage 3: six products and the gaps for both axes
  always_comb begin
    {satx_nxt, gx_nxt} = gap_of(sel.nx, margin, sel.spx);
    {saty_nxt, gy_nxt} = gap_of(sel.ny, margin, sel.spy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r      <= sx_s(sel.spx) * $signed({{(PW-TW){1'b0}}, sel.dt});
      p1_r      <= sx_s(sel.spy) * $signed({{(PW-TW){1'b0}}, sel.dt});
      p2_r      <= sx_g(sel.ny) * sx_s(sel.spx);
      p3_r      <= sx_g(sel.nx) * sx_s(sel.spy);
      p4_r      <= sx_g(sel.fy) * sx_s(sel.spx);
      p5_r      <= sx_g(sel.fx) * sx_s(sel.spy);
      nx_r      <= sel.nx;
      ny_r      <= sel.ny;
      gx_r      <= gx_nxt;
      gy_r      <= gy_nxt;
      satx_r    <= satx_nxt;
      saty_r    <= saty_nxt;
      spx_r     <= sel.spx[TW-1:0];
      spy_r     <= sel.spy[TW-1:0];
      dt_r      <= sel.dt;
      miss_r    <= sel.miss;
      overlap_r <= sel.overlap;
      corner_r  <= sel.corner;
      cnz_r     <= sel.cross_nz;
    end
  end

  // stage 4: hit decision, choice of axis, and the fixed results
  always_comb begin
    logic signed [PW-1:0] nxs, nys;
    logic okx, oky, ab, hit, usey, sat;
    logic [GW-1:0] g;
    logic [TW-1:0] sp;
    nxs  = $signed({{(PW-GW-sbti_pkg::FRAC_T){nx_r[GW-1]}}, nx_r, {sbti_pkg::FRAC_T{1'b0}}});
    nys  = $signed({{(PW-GW-sbti_pkg::FRAC_T){ny_r[GW-1]}}, ny_r, {sbti_pkg::FRAC_T{1'b0}}});
    okx  = (p0_r >= nxs);
    oky  = (p1_r >= nys);
    ab   = (p2_r <= p3_r);
    hit  = corner_r ? (okx && oky && (ab ? (p3_r <= p4_r) : (p2_r <= p5_r)))
                    : (okx && (!cnz_r || (p3_r <= p4_r)));
    usey = corner_r && !ab;
    g    = usey ? gy_r : gx_r;
    sp   = usey ? spy_r : spx_r;
    sat  = usey ? saty_r : satx_r;

    div_nxt.rem = {{(sbti_pkg::NUM_W-GW-sbti_pkg::FRAC_T){1'b0}}, g, {sbti_pkg::FRAC_T{1'b0}}};
    div_nxt.den = sp;
    priority if (miss_r) begin
      div_nxt.hit = 1'b0; div_nxt.fixed = 1'b1; div_nxt.q = dt_r;
    end else if (overlap_r) begin
      div_nxt.hit = 1'b1; div_nxt.fixed = 1'b1; div_nxt.q = '0;
    end else if (!hit) begin
      div_nxt.hit = 1'b0; div_nxt.fixed = 1'b1; div_nxt.q = dt_r;
    end else if (sp == '0) begin
      div_nxt.hit = 1'b1; div_nxt.fixed = 1'b1; div_nxt.q = '0;
    end else if (sat) begin
      div_nxt.hit = 1'b1; div_nxt.fixed = 1'b1; div_nxt.q = sbti_pkg::TIME_MAX;
    end else begin
      div_nxt.hit = 1'b1; div_nxt.fixed = 1'b0; div_nxt.q = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign div_valid = v4_r;
  assign div_in    = div_r;

endmodule

@@ hw/rtl/sbti_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage
module sbti_divider (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            div_valid,
  input  sbti_pkg::div_t  div_in,
  output logic            res_valid,
  output sbti_pkg::div_t  res
);

  localparam int unsigned NS = sbti_pkg::TIME_W;

  sbti_pkg::div_t st_r [NS];
  logic [NS-1:0]  v_r;

  // valid bits move with the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], div_valid};
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int unsigned B = NS - 1 - k;
    sbti_pkg::div_t prev, nxt;
    logic [sbti_pkg::NUM_W-1:0] dsh;

    if (k == 0) begin : g_first
      assign prev = div_in;
    end else begin : g_rest
      assign prev = st_r[k-1];
    end

    // try to subtract the divisor shifted to this bit
    always_comb begin
      nxt = prev;
      dsh = {{(sbti_pkg::NUM_W-NS){1'b0}}, prev.den} << B;
      if (!prev.fixed && (prev.rem >= dsh)) begin
        nxt.rem  = prev.rem - dsh;
        nxt.q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= nxt;
      end
    end
  end

  assign res_valid = v_r[NS-1];
  assign res       = st_r[NS-1];

endmodule

@@ hw/rtl/sbti_checker.sv @@
// Port-level checks of the swept box time of impact unit, bound to the top level
`include "swept_box_time_of_impact_unit_defines.svh"

module sbti_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_hit,
  input logic [sbti_pkg::TIME_W-1:0]  out_contact_time
);

  logic held;

  // result waiting on the receiver
  assign held = out_valid && !out_ready;

  // reset empties the pipeline
  `SBTI_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  // a held result stays
  `SBTI_ASSERT(a_out_hold, held |=> out_valid, "held result dropped")

  // a held result does not change
  `SBTI_ASSERT(a_out_stable, held |=> $stable({out_hit, out_contact_time}), "held result changed")

  // intake stalls exactly when the output is held
  `SBTI_ASSERT(a_ready_link, in_ready == (!out_valid || out_ready), "ready not tied to stall")

endmodule

bind swept_box_time_of_impact_unit sbti_checker u_sbti_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_req.ready),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_hit          (out_rsp.hit),
  .out_contact_time (out_rsp.contact_time)
);
